// ===== design/scfp_pkg.sv =====
// Shared package for the sync checksum frame parser.
// Holds field widths, reset values, register indexes and the inter-module structs.
package scfp_pkg;

    localparam int DATA_W           = 8;
    localparam int IDX_W            = 5;
    localparam int ERR_W            = 16;
    localparam int TDATA_W          = 32;
    localparam int FRAME_LENGTH_DEF = 30;
    localparam int CFG_IDX_W        = 1;

    localparam logic [DATA_W-1:0]    SYNC_FIRST_RST  = 8'h88;
    localparam logic [DATA_W-1:0]    SYNC_SECOND_RST = 8'hAF;
    localparam logic [ERR_W-1:0]     ERR_MAX         = 16'hFFFF;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             good;
        logic [ERR_W-1:0] err_count;
    } t_frame_end;

    typedef struct packed {
        logic busy;
        logic out_full;
    } t_emit_stat;

endpackage

// ===== design/scfp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module scfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/scfp_collect.sv =====
// Input side: sync hunt, frame byte store writes, running checksum, failure counter.
// Depends on scfp_pkg; writes the frame store held in scfp_ram.
module scfp_collect
    import scfp_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
    localparam int CNT_W = $clog2(FRAME_LENGTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic [DATA_W-1:0]    i_s_tdata,
    output logic                 o_s_tready,
    input  t_emit_stat           i_emit_stat,
    output logic                 o_ram_we,
    output logic [CNT_W-1:0]     o_ram_waddr,
    output logic [DATA_W-1:0]    o_ram_wdata,
    output t_frame_end           o_frame_end
);

    localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LENGTH);

    logic [DATA_W-1:0] r_sync_first, r_sync_second;
    logic [DATA_W-1:0] r_prev, r_check_sum, r_psum;
    logic              r_in_frame;
    logic [CNT_W-1:0]  r_count;
    logic [ERR_W-1:0]  r_fail;

    logic              take, hit, in_frame_now, frame_end, good;
    logic [DATA_W-1:0] pair_sum, cs_eff, total;
    logic [ERR_W-1:0]  fail_inc;

    assign o_s_tready   = !i_emit_stat.busy && (r_count != LAST_POS || !i_emit_stat.out_full);
    assign take         = i_s_tvalid && o_s_tready;
    assign hit          = (i_s_tdata == r_sync_second) && (r_prev == r_sync_first);
    assign pair_sum     = r_sync_first + r_sync_second;
    assign in_frame_now = r_in_frame || hit;
    assign frame_end    = take && in_frame_now && (r_count == LAST_POS);
    assign cs_eff       = hit ? pair_sum : r_check_sum;
    assign total        = cs_eff + r_psum;
    assign good         = (total == i_s_tdata);
    assign fail_inc     = (r_fail == ERR_MAX) ? r_fail : r_fail + 1'b1;

    assign o_ram_we    = take && in_frame_now;
    assign o_ram_waddr = r_count;
    assign o_ram_wdata = i_s_tdata;

    assign o_frame_end.valid     = frame_end;
    assign o_frame_end.good      = good;
    assign o_frame_end.err_count = good ? r_fail : fail_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_prev        <= '0;
            r_check_sum   <= SYNC_FIRST_RST + SYNC_SECOND_RST;
            r_psum        <= '0;
            r_in_frame    <= 1'b0;
            r_count       <= '0;
            r_fail        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_wdata;
                    CFG_SYNC_SECOND: r_sync_second <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (take) begin
                r_prev <= i_s_tdata;
                if (hit) begin
                    r_check_sum <= pair_sum;
                end
                if (in_frame_now) begin
                    if (r_count == LAST_POS) begin
                        r_in_frame <= 1'b0;
                        r_count    <= '0;
                        r_psum     <= '0;
                        if (!good) begin
                            r_fail <= fail_inc;
                        end
                    end else begin
                        r_in_frame <= 1'b1;
                        r_count    <= r_count + 1'b1;
                        if (r_count != '0) begin
                            r_psum <= r_psum + i_s_tdata;
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== design/scfp_emit.sv =====
// Output side: reads payload bytes back from the frame store and drives the result register.
// Depends on scfp_pkg; reads the frame store held in scfp_ram.
module scfp_emit
    import scfp_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF,
    localparam int CNT_W = $clog2(FRAME_LENGTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_frame_end        i_frame_end,
    output t_emit_stat        o_emit_stat,
    output logic              o_ram_re,
    output logic [CNT_W-1:0]  o_ram_raddr,
    input  logic [DATA_W-1:0] i_ram_rdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [DATA_W-1:0] o_payload_byte,
    output logic [IDX_W-1:0]  o_byte_index,
    output logic              o_last,
    output logic              o_frame_good,
    output logic [ERR_W-1:0]  o_error_count
);

    localparam logic [CNT_W-1:0] END_ADDR  = CNT_W'(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(FRAME_LENGTH - 1);

    typedef enum logic {
        E_IDLE,
        E_RUN
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_rd_addr, r_pend_addr;
    logic             r_pend, r_out_valid;
    logic [ERR_W-1:0] r_err;

    logic             take, land, issue;
    logic [CNT_W-1:0] pend_pos;

    assign take     = r_out_valid && i_m_tready;
    assign land     = r_pend && (!r_out_valid || take);
    assign issue    = (r_state == E_RUN) && (r_rd_addr != END_ADDR) && (!r_pend || land);
    assign pend_pos = r_pend_addr - 1'b1;

    assign o_ram_re    = issue;
    assign o_ram_raddr = r_rd_addr;
    assign o_m_tvalid  = r_out_valid;

    assign o_emit_stat.busy     = (r_state == E_RUN);
    assign o_emit_stat.out_full = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_addr   <= '0;
        end else begin
            if (issue) begin
                r_rd_addr   <= r_rd_addr + 1'b1;
                r_pend_addr <= r_rd_addr;
            end
            r_pend <= issue || (r_pend && !land);

            if (land) begin
                r_out_valid    <= 1'b1;
                o_payload_byte <= i_ram_rdata;
                o_byte_index   <= IDX_W'(pend_pos);
                o_last         <= (r_pend_addr == LAST_ADDR);
                o_frame_good   <= 1'b1;
                o_error_count  <= r_err;
            end else if (i_frame_end.valid && !i_frame_end.good) begin
                r_out_valid    <= 1'b1;
                o_payload_byte <= '0;
                o_byte_index   <= '0;
                o_last         <= 1'b1;
                o_frame_good   <= 1'b0;
                o_error_count  <= i_frame_end.err_count;
            end else if (take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                E_IDLE: begin
                    if (i_frame_end.valid && i_frame_end.good) begin
                        r_state   <= E_RUN;
                        r_rd_addr <= CNT_W'(1);
                        r_err     <= i_frame_end.err_count;
                    end
                end
                E_RUN: begin
                    if (land && r_pend_addr == LAST_ADDR) begin
                        r_state <= E_IDLE;
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

endmodule

// ===== design/sync_checksum_frame_parser_core.sv =====
// Top level of the sync checksum frame parser: collector, frame store RAM, emitter.
// Depends on scfp_pkg, scfp_ram, scfp_collect and scfp_emit.
// A good frame's first payload beat passes the emitter state, frame store read and
// output registers after its checksum beat; an error beat is registered straight into
// the output register. Payload beats then follow one per cycle while the sink is ready.
// Throughput: one input beat per cycle while collecting; stalls while the store drains.
// Reset (synchronous, active low) restores sync bytes 0x88/0xAF and clears the counters.
module sync_checksum_frame_parser_core
    import scfp_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [DATA_W-1:0]    i_s_tdata,   // [7:0] data_byte
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TDATA_W-1:0]   o_m_tdata,   // [7:0] payload_byte, [12:8] byte_index,
                                              // [28:13] error_count, [31:29] zero
    output logic                 o_m_tlast,
    output logic                 o_m_tuser    // [0] frame_good
);

    localparam int CNT_W = $clog2(FRAME_LENGTH + 1);

    t_frame_end        frame_end;
    t_emit_stat        emit_stat;
    logic              ram_we, ram_re;
    logic [CNT_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;
    logic [DATA_W-1:0] payload_byte;
    logic [IDX_W-1:0]  byte_index;
    logic [ERR_W-1:0]  error_count;

    scfp_collect #(.FRAME_LENGTH(FRAME_LENGTH)) u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .o_s_tready  (o_s_tready),
        .i_emit_stat (emit_stat),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_frame_end (frame_end)
    );

    scfp_ram #(.WIDTH(DATA_W), .DEPTH(FRAME_LENGTH + 1)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    scfp_emit #(.FRAME_LENGTH(FRAME_LENGTH)) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_end    (frame_end),
        .o_emit_stat    (emit_stat),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .o_payload_byte (payload_byte),
        .o_byte_index   (byte_index),
        .o_last         (o_m_tlast),
        .o_frame_good   (o_m_tuser),
        .o_error_count  (error_count)
    );

    assign o_m_tdata = {3'b000, error_count, byte_index, payload_byte};

    a_no_intake_while_draining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_stat.busy |-> !o_s_tready)
        else $error("input accepted while payload drains");

    a_error_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tlast && o_m_tdata[12:0] == 13'd0))
        else $error("error beat not single, last and zero payload");

    a_last_good_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser && o_m_tlast) |-> (byte_index == IDX_W'(FRAME_LENGTH - 2)))
        else $error("last payload beat at wrong index");

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for sync_checksum_frame_parser_core: byte streams with sync headers,
// good and corrupted checksums, and sync pairs inside frames are checked beat by beat
// against a built-in frame parser model. Depends on scfp_pkg and the core RTL.
module testbench;
    import scfp_pkg::*;

    localparam int STORE_DEPTH = FRAME_LENGTH_DEF + 1;
    localparam int PAD_W       = TDATA_W - DATA_W - IDX_W - ERR_W;

    typedef struct packed {
        logic [ERR_W-1:0]  err_count;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] payload;
        logic              last;
        logic              good;
    } t_parsed_beat;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_SYNC_FIRST;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic [DATA_W-1:0]    i_s_tdata   = '0;
    logic                 i_m_tready  = 1'b0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [TDATA_W-1:0]   o_m_tdata;
    logic                 o_m_tlast;
    logic                 o_m_tuser;

    // stimulus and model state
    logic [DATA_W-1:0] rx_bytes[$];
    t_parsed_beat      predicted_beats[$];
    logic [DATA_W-1:0] frame_bytes[0:STORE_DEPTH];

    logic [DATA_W-1:0] hunt_first  = SYNC_FIRST_RST;
    logic [DATA_W-1:0] hunt_second = SYNC_SECOND_RST;
    logic [DATA_W-1:0] last_byte   = '0;
    logic              framing     = 1'b0;
    logic [5:0]        fill_count  = '0;
    logic [DATA_W-1:0] frame_buf[0:STORE_DEPTH-1];
    logic [DATA_W-1:0] sum_seed    = SYNC_FIRST_RST + SYNC_SECOND_RST;
    logic [ERR_W-1:0]  fail_count  = '0;

    logic         calm      = 1'b0;
    logic         hold_used = 1'b0;
    int           hold_left = 0;
    int           out_beats = 0;
    int           mismatch_count = 0;
    t_parsed_beat want;
    logic [TDATA_W-1:0] want_data;

    sync_checksum_frame_parser_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    task automatic parse_byte(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] sum;
        t_parsed_beat      pb;
        int                k;
        if (b == hunt_second && last_byte == hunt_first) begin
            framing  = 1'b1;
            sum_seed = hunt_first + hunt_second;
        end
        last_byte = b;
        if (framing) begin
            if (fill_count < STORE_DEPTH)
                frame_buf[fill_count] = b;
            fill_count = fill_count + 6'd1;
            if (fill_count > FRAME_LENGTH_DEF) begin
                sum = sum_seed;
                for (k = 1; k < FRAME_LENGTH_DEF; k++)
                    sum = sum + frame_buf[k];
                if (sum == frame_buf[FRAME_LENGTH_DEF]) begin
                    for (k = 1; k < FRAME_LENGTH_DEF; k++) begin
                        pb.payload   = frame_buf[k];
                        pb.index     = IDX_W'(k - 1);
                        pb.last      = (k == FRAME_LENGTH_DEF - 1);
                        pb.good      = 1'b1;
                        pb.err_count = fail_count;
                        predicted_beats.push_back(pb);
                    end
                end else begin
                    if (fail_count != ERR_MAX)
                        fail_count = fail_count + 1'b1;
                    pb.payload   = '0;
                    pb.index     = '0;
                    pb.last      = 1'b1;
                    pb.good      = 1'b0;
                    pb.err_count = fail_count;
                    predicted_beats.push_back(pb);
                end
                fill_count = '0;
                framing    = 1'b0;
            end
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready)
            parse_byte(i_s_tdata);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (rx_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= rx_bytes.pop_front();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            out_beats <= out_beats + 1;
            if (predicted_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual tdata %h tlast %b tuser %b",
                         $time, o_m_tdata, o_m_tlast, o_m_tuser);
                mismatch_count++;
            end else begin
                want      = predicted_beats.pop_front();
                want_data = {{PAD_W{1'b0}}, want.err_count, want.index, want.payload};
                if (o_m_tdata !== want_data || o_m_tlast !== want.last
                        || o_m_tuser !== want.good) begin
                    $display({"%0t: beat mismatch, expected tdata %h tlast %b tuser %b,",
                              " actual tdata %h tlast %b tuser %b"},
                             $time, want_data, want.last, want.good,
                             o_m_tdata, o_m_tlast, o_m_tuser);
                    mismatch_count++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_used && out_beats >= 100 && o_m_tvalid) begin
            hold_used  <= 1'b1;
            hold_left  <= 400;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm || $urandom_range(0, 99) >= 18;
        end
    end

    // frame_bytes: header pair, 29 payload bytes, checksum; inner pair at payload position
    task automatic build_frame(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                               input logic [DATA_W-1:0] inner_a,
                               input logic [DATA_W-1:0] inner_b,
                               input int inner_at, input bit good);
        logic [DATA_W-1:0] sum;
        int                k;
        frame_bytes[0] = a;
        frame_bytes[1] = b;
        sum = (inner_at >= 0) ? inner_a + inner_b : a + b;
        for (k = 0; k < FRAME_LENGTH_DEF - 1; k++) begin
            if (inner_at >= 0 && k == inner_at)
                frame_bytes[k + 2] = inner_a;
            else if (inner_at >= 0 && k == inner_at + 1)
                frame_bytes[k + 2] = inner_b;
            else
                frame_bytes[k + 2] = DATA_W'($urandom_range(0, 255));
            sum = sum + frame_bytes[k + 2];
        end
        frame_bytes[STORE_DEPTH] = good ? sum : sum + DATA_W'($urandom_range(1, 255));
    endtask

    task automatic push_frame(input int from, input int upto);
        int k;
        for (k = from; k <= upto; k++)
            rx_bytes.push_back(frame_bytes[k]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        if (idx == CFG_SYNC_FIRST)
            hunt_first = value;
        else
            hunt_second = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        do
            @(posedge i_clk);
        while (rx_bytes.size() != 0 || i_s_tvalid || predicted_beats.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic queue_traffic(input int n_items);
        int pushed;
        int pick;
        int k;
        pushed = 0;
        while (pushed < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                if (pick < 60)
                    build_frame(hunt_first, hunt_second, hunt_first, hunt_second, -1, 1'b1);
                else if (pick < 75)
                    build_frame(hunt_first, hunt_second, hunt_first, hunt_second, -1, 1'b0);
                else
                    build_frame(hunt_first, hunt_second, hunt_first, hunt_second,
                                $urandom_range(0, 27), $urandom_range(0, 3) != 0);
                push_frame(0, STORE_DEPTH);
                pushed += STORE_DEPTH + 1;
            end else begin
                k = $urandom_range(1, 6);
                pushed += k;
                if ($urandom_range(0, 1) != 0) begin
                    rx_bytes.push_back(hunt_first);
                    k--;
                end
                repeat (k) rx_bytes.push_back(DATA_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(8'hFF);
        rx_bytes.push_back(hunt_first);
        build_frame(hunt_first, hunt_second, hunt_first, hunt_second, 10, 1'b1);
        push_frame(0, STORE_DEPTH);
        build_frame(hunt_first, hunt_second, hunt_first, hunt_second, -1, 1'b0);
        push_frame(0, STORE_DEPTH);
        wait_drain();

        // change sync bytes mid-frame; the inner pair then reloads the new sum
        build_frame(hunt_first, hunt_second, 8'h00, 8'hFF, 15, 1'b1);
        push_frame(0, 12);
        wait_drain();
        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        push_frame(13, STORE_DEPTH);
        wait_drain();

        write_reg(CFG_SYNC_FIRST, 8'hFF);
        write_reg(CFG_SYNC_SECOND, 8'h00);
        calm <= 1'b1;
        queue_traffic(90);
        wait_drain();
        calm <= 1'b0;

        write_reg(CFG_SYNC_FIRST, SYNC_FIRST_RST);
        write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
        queue_traffic(100);
        wait_drain();

        write_reg(CFG_SYNC_FIRST, DATA_W'($urandom_range(0, 255)));
        write_reg(CFG_SYNC_SECOND, DATA_W'($urandom_range(0, 255)));
        queue_traffic(70);
        wait_drain();

        write_reg(CFG_SYNC_FIRST, 8'h5A);
        write_reg(CFG_SYNC_SECOND, 8'h5A);
        queue_traffic(45);
        wait_drain();

        if (mismatch_count == 0)
            $display("sync_checksum_frame_parser_core verification clean");
        else
            $display("sync_checksum_frame_parser_core verification failed");
        $finish;
    end

    initial begin
        #3000000;
        $display("sync_checksum_frame_parser_core verification failed");
        $finish;
    end

endmodule
